FILE: hw/rtl/sapava_pkg.sv
// Shared types, constants and codes for the sequential antitonic PAVA CDF block.
// Used by sapava_div, sapava_core and sequential_antitonic_pava_cdf; no dependencies.
package sapava_pkg;

	// count and index width of the fixed fields (positions, grid columns)
	localparam int CW = 7;
	localparam int WORD = 32;
	// pooled block weight, block mean and wide numerator widths
	localparam int BWW = 40;
	localparam int BMW = 33;
	localparam int NUMW = 74;
	localparam int PRODW = 65;

	localparam int MAX_POSITIONS_DEF = 64;
	localparam int MAX_GRID_DEF = 64;

	localparam logic [CW-1:0] REG_RESET = 7'd64;
	localparam logic [WORD-1:0] ONE_Q31 = 32'h8000_0000;

	// register indexes on the configuration port
	localparam logic REG_POSITIONS = 1'b0;
	localparam logic REG_GRID = 1'b1;

	typedef enum logic [1:0] {
		FN_WEIGHT = 2'd0,
		FN_OBS = 2'd1,
		FN_GRID = 2'd2,
		FN_FINISH = 2'd3
	} func_t;

	typedef struct packed {
		logic [CW-1:0] bend;
		logic [BWW-1:0] wt;
		logic [BMW-1:0] mean;
	} block_t;

	typedef struct packed {
		logic [CW-1:0] m;
		logic [CW-1:0] g;
		logic clear;
	} cfg_t;

	typedef struct packed {
		logic [CW-1:0] m_eff;
		logic div_busy;
	} stat_t;

	typedef enum logic [5:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_EM_RD, S_EM_CMP, S_EM_OUT,
		S_TOP_RD, S_TOP_CMP, S_F_RD, S_F_DIV, S_F_WAIT, S_F_INIT,
		S_FS_RD, S_FS_CMP, S_B0_RD, S_A0_RD, S_A0_GET, S_TC_RD, S_TC_WR,
		S_SUM_RD, S_SUM_MUL, S_SUM_ADD, S_SUM_DIV, S_SUM_WAIT,
		S_PL_CHK, S_PL_CMP, S_PL_MUL, S_PL_ADD, S_PL_DIVS, S_PL_WAIT, S_PL_DONE,
		S_SG_CHK, S_SG_GET, S_TL_RD, S_TL_WR, S_DONE
	} state_t;

endpackage

FILE: hw/rtl/sapava_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag above the kept bits.
// Depends on sapava_pkg for widths.
module sapava_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [sapava_pkg::NUMW-1:0] num,
	input  logic [sapava_pkg::BWW-1:0] den,
	output logic busy,
	output logic done,
	output logic [sapava_pkg::BMW-1:0] quo,
	output logic ovf
);
	localparam int NW = sapava_pkg::NUMW;
	localparam int DW = sapava_pkg::BWW;
	localparam int QW = sapava_pkg::BMW;
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] r_q;
	logic [QW-1:0] q_q;
	logic ovf_q;
	logic [KW-1:0] k_q;
	logic busy_q, done_q;

	logic [DW:0] trial;
	logic fits;

	// one trial subtraction per cycle
	assign trial = {r_q, n_q[NW-1]};
	assign fits = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= KW'(NW);
			end else if (busy_q) begin
				k_q <= k_q - KW'(1);
				if (k_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			r_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
			q_q <= {q_q[QW-2:0], fits};
			ovf_q <= ovf_q | q_q[QW-1];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = q_q;
	assign ovf = ovf_q;
endmodule

FILE: hw/rtl/sapava_core.sv
// Sequencer and state memories: grid scan, snapshot emit, fraction update, split and pool.
// Depends on sapava_pkg and sapava_div.
module sapava_core #(
	parameter int MAX_POSITIONS = sapava_pkg::MAX_POSITIONS_DEF,
	parameter int MAX_GRID = sapava_pkg::MAX_GRID_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  sapava_pkg::cfg_t cfg,
	output sapava_pkg::stat_t stat,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [5:0] position,
	input  logic [31:0] amount,
	input  logic signed [31:0] y_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [5:0] out_position,
	output logic [31:0] fitted_value,
	output logic [6:0] column_count,
	output logic last
);
	localparam int CW = sapava_pkg::CW;
	localparam int PAW = $clog2(MAX_POSITIONS);
	localparam int BAW = $clog2(MAX_POSITIONS + 1);
	localparam int GAW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int NW = sapava_pkg::NUMW;
	localparam int BWW = sapava_pkg::BWW;
	localparam int BMW = sapava_pkg::BMW;
	localparam int PW = sapava_pkg::PRODW;
	localparam logic [CW-1:0] MAXP = CW'(MAX_POSITIONS);
	localparam logic [CW-1:0] MAXG = CW'(MAX_GRID);

	// memories
	logic [31:0] wmem [MAX_POSITIONS];
	logic [31:0] fmem [MAX_POSITIONS];
	logic [MAX_POSITIONS-1:0] fval_q;
	logic [31:0] gmem [MAX_GRID];
	sapava_pkg::block_t bmem [MAX_POSITIONS+1];
	sapava_pkg::block_t tmem [MAX_POSITIONS];

	logic [31:0] w_rd, f_rd;
	logic signed [31:0] g_rd;
	sapava_pkg::block_t b_rd, t_rd;

	logic w_we, g_we, f_we, b_we, t_we, fclr;
	logic [31:0] f_wd;
	sapava_pkg::block_t b_wd, t_wd;
	logic [CW-1:0] pa, ba, ta, ga, b_wa, t_wa;

	// divider
	logic div_start, div_busy, div_done, div_ovf;
	logic [NW-1:0] div_num;
	logic [BWW-1:0] div_den;
	logic [BMW-1:0] div_q;

	// sequencer state
	sapava_pkg::state_t state_q, state_d;
	sapava_pkg::func_t func_q, func_d;
	logic [5:0] j_q, j_d;
	logic [31:0] amt_q, amt_d;
	logic signed [31:0] y_q, y_d, prev_q, prev_d, thr;
	logic first_q, first_d;
	logic [CW-1:0] cursor_q, cursor_d, cnt_q, cnt_d, c_q, c_d, cols_q, cols_d;
	logic [CW-1:0] p_q, p_d, s_q, s_d, b0_q, b0_d, i_q, i_d;
	logic [CW-1:0] k_q, k_d, t_q, t_d, d_q, d_d;
	logic scan_b_q, scan_b_d, ones_q, ones_d, in_sg_q, in_sg_d, sh_q, sh_d;
	logic [31:0] v_q, v_d, frac_q, frac_d;
	sapava_pkg::block_t cur_q, cur_d, prv_q, prv_d;
	logic [NW-1:0] acc_q, acc_d;
	logic [BWW-1:0] ws_q, ws_d;
	logic [PW-1:0] prod_q, prod_d;
	logic [1:0] step_q, step_d;
	logic ovalid_q, ovalid_d, olast_q, olast_d;
	logic [5:0] opos_q, opos_d;
	logic [31:0] ofv_q, ofv_d;
	logic [CW-1:0] occ_q, occ_d;

	logic [CW-1:0] m_eff, g_eff, m_last;
	logic [31:0] mul_a;
	logic [BMW-1:0] mul_b;
	logic [PW-1:0] prod_c;
	logic [33:0] z_sum;
	logic clr_run, accept;

	// clamped register values
	always_comb begin
		m_eff = cfg.m;
		if (cfg.m == '0) m_eff = CW'(1);
		else if (cfg.m > MAXP) m_eff = MAXP;
		g_eff = cfg.g;
		if (cfg.g == '0) g_eff = CW'(1);
		else if (cfg.g > MAXG) g_eff = MAXG;
	end
	assign m_last = m_eff - CW'(1);

	// memory ports, read data registered
	always_ff @(posedge clk) begin
		if (w_we) wmem[position[PAW-1:0]] <= amount;
		if (f_we) fmem[j_q[PAW-1:0]] <= f_wd;
		if (g_we) gmem[position[GAW-1:0]] <= y_value;
		if (b_we) bmem[b_wa[BAW-1:0]] <= b_wd;
		if (t_we) tmem[t_wa[PAW-1:0]] <= t_wd;
		w_rd <= wmem[pa[PAW-1:0]];
		f_rd <= fval_q[pa[PAW-1:0]] ? fmem[pa[PAW-1:0]] : 32'd0;
		g_rd <= gmem[ga[GAW-1:0]];
		b_rd <= bmem[ba[BAW-1:0]];
		t_rd <= tmem[ta[PAW-1:0]];
	end

	// fraction valid bits stand in for the all-zero reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fval_q <= '0;
		else if (fclr) fval_q <= '0;
		else if (f_we) fval_q[j_q[PAW-1:0]] <= 1'b1;
	end

	sapava_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_q), .ovf(div_ovf)
	);

	// shared multiplier
	assign prod_c = PW'(mul_a) * PW'(mul_b);
	assign z_sum = 34'(frac_q) + 34'(div_q);
	assign thr = (first_q && !scan_b_q) ? prev_q : y_q;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == sapava_pkg::S_IDLE);

	always_comb begin
		state_d = state_q; func_d = func_q; j_d = j_q; amt_d = amt_q; y_d = y_q;
		prev_d = prev_q; first_d = first_q; cursor_d = cursor_q; cnt_d = cnt_q;
		c_d = c_q; cols_d = cols_q; p_d = p_q; s_d = s_q; b0_d = b0_q; i_d = i_q;
		k_d = k_q; t_d = t_q; d_d = d_q; scan_b_d = scan_b_q; ones_d = ones_q;
		in_sg_d = in_sg_q; sh_d = sh_q; v_d = v_q; frac_d = frac_q; cur_d = cur_q;
		prv_d = prv_q; acc_d = acc_q; ws_d = ws_q; prod_d = prod_q; step_d = step_q;
		ovalid_d = ovalid_q; olast_d = olast_q; opos_d = opos_q; ofv_d = ofv_q;
		occ_d = occ_q;
		w_we = 1'b0; g_we = 1'b0; f_we = 1'b0; b_we = 1'b0; t_we = 1'b0;
		f_wd = frac_q; b_wd = cur_q; t_wd = b_rd; b_wa = d_q; t_wa = k_q;
		pa = i_q; ba = s_q; ta = k_q; ga = c_q;
		div_start = 1'b0; div_num = acc_q; div_den = ws_q;
		mul_a = w_rd; mul_b = {1'b0, f_rd};
		clr_run = cfg.clear;

		// output register drains independently of the sequencer
		if (out_ready) ovalid_d = 1'b0;

		unique case (state_q)
			sapava_pkg::S_IDLE: begin
				if (accept) begin
					func_d = sapava_pkg::func_t'(func);
					j_d = position;
					amt_d = amount;
					y_d = y_value;
					unique case (sapava_pkg::func_t'(func))
						sapava_pkg::FN_WEIGHT: w_we = (CW'(position) < MAXP);
						sapava_pkg::FN_GRID: g_we = (CW'(position) < MAXG);
						sapava_pkg::FN_FINISH: begin
							ones_d = 1'b1;
							cols_d = g_eff - cursor_q;
							p_d = '0;
							clr_run = 1'b1;
							if (first_q && cursor_q < g_eff) state_d = sapava_pkg::S_EM_RD;
						end
						sapava_pkg::FN_OBS: begin
							c_d = cursor_q;
							scan_b_d = 1'b0;
							if (CW'(position) < m_eff) begin
								if (!first_q || y_value > prev_q) state_d = sapava_pkg::S_SCAN_RD;
								else state_d = sapava_pkg::S_TOP_RD;
							end
						end
						default: ;
					endcase
				end
			end

			// grid cursor scans, each grid point read and then compared
			sapava_pkg::S_SCAN_RD, sapava_pkg::S_SCAN_CMP: begin
				if (state_q == sapava_pkg::S_SCAN_RD && c_q < g_eff) begin
					ga = c_q;
					state_d = sapava_pkg::S_SCAN_CMP;
				end else if (state_q == sapava_pkg::S_SCAN_CMP && g_rd < thr) begin
					c_d = c_q + CW'(1);
					state_d = sapava_pkg::S_SCAN_RD;
				end else if (!first_q) begin
					cursor_d = c_q;
					state_d = sapava_pkg::S_TOP_RD;
				end else if (!scan_b_q) begin
					cursor_d = c_q;
					scan_b_d = 1'b1;
					state_d = sapava_pkg::S_SCAN_RD;
				end else if (c_q > cursor_q) begin
					cols_d = c_q - cursor_q;
					cursor_d = c_q;
					ones_d = 1'b0;
					p_d = '0;
					s_d = CW'(1);
					state_d = sapava_pkg::S_EM_RD;
				end else begin
					state_d = sapava_pkg::S_TOP_RD;
				end
			end

			// snapshot: walk blocks alongside positions
			sapava_pkg::S_EM_RD: begin
				ba = s_q;
				if (ones_q) begin
					v_d = sapava_pkg::ONE_Q31;
					state_d = sapava_pkg::S_EM_OUT;
				end else if (s_q <= cnt_q) begin
					state_d = sapava_pkg::S_EM_CMP;
				end else begin
					v_d = '0;
					state_d = sapava_pkg::S_EM_OUT;
				end
			end
			sapava_pkg::S_EM_CMP: begin
				if (b_rd.bend < p_q) begin
					s_d = s_q + CW'(1);
					state_d = sapava_pkg::S_EM_RD;
				end else begin
					v_d = b_rd.mean[31:0];
					state_d = sapava_pkg::S_EM_OUT;
				end
			end
			sapava_pkg::S_EM_OUT: begin
				if (!ovalid_q || out_ready) begin
					ovalid_d = 1'b1;
					opos_d = p_q[5:0];
					ofv_d = v_q;
					occ_d = cols_q;
					olast_d = (p_q == m_last);
					p_d = p_q + CW'(1);
					if (p_q == m_last)
						state_d = (func_q == sapava_pkg::FN_OBS) ? sapava_pkg::S_TOP_RD
							: sapava_pkg::S_IDLE;
					else state_d = sapava_pkg::S_EM_RD;
				end
			end

			// responses above the top grid point skip the fit
			sapava_pkg::S_TOP_RD: begin
				ga = g_eff - CW'(1);
				state_d = sapava_pkg::S_TOP_CMP;
			end
			sapava_pkg::S_TOP_CMP: begin
				state_d = (y_q <= g_rd) ? sapava_pkg::S_F_RD : sapava_pkg::S_DONE;
			end

			// fraction update of the observed position
			sapava_pkg::S_F_RD: begin
				pa = CW'(j_q);
				state_d = sapava_pkg::S_F_DIV;
			end
			sapava_pkg::S_F_DIV: begin
				frac_d = f_rd;
				if (w_rd == '0) begin
					f_we = 1'b1;
					f_wd = sapava_pkg::ONE_Q31;
					state_d = sapava_pkg::S_F_INIT;
				end else begin
					div_start = 1'b1;
					div_num = NW'({amt_q, 31'd0});
					div_den = BWW'(w_rd);
					state_d = sapava_pkg::S_F_WAIT;
				end
			end
			sapava_pkg::S_F_WAIT: begin
				if (div_done) begin
					f_we = 1'b1;
					f_wd = (div_ovf || z_sum > 34'(sapava_pkg::ONE_Q31)) ? sapava_pkg::ONE_Q31
						: z_sum[31:0];
					state_d = sapava_pkg::S_F_INIT;
				end
			end
			sapava_pkg::S_F_INIT: begin
				if (cnt_q == '0) begin
					b_we = 1'b1;
					b_wa = CW'(1);
					b_wd = '{bend: m_last, wt: '0, mean: '0};
					cnt_d = CW'(1);
				end
				s_d = CW'(1);
				state_d = sapava_pkg::S_FS_RD;
			end

			// find the block that holds the position
			sapava_pkg::S_FS_RD: begin
				ba = s_q;
				state_d = (s_q < cnt_q) ? sapava_pkg::S_FS_CMP : sapava_pkg::S_B0_RD;
			end
			sapava_pkg::S_FS_CMP: begin
				if (b_rd.bend < CW'(j_q)) begin
					s_d = s_q + CW'(1);
					state_d = sapava_pkg::S_FS_RD;
				end else state_d = sapava_pkg::S_B0_RD;
			end
			sapava_pkg::S_B0_RD: begin
				ba = s_q;
				state_d = sapava_pkg::S_A0_RD;
			end
			sapava_pkg::S_A0_RD: begin
				b0_d = (b_rd.bend >= m_eff) ? m_last : b_rd.bend;
				ba = s_q - CW'(1);
				state_d = sapava_pkg::S_A0_GET;
			end
			sapava_pkg::S_A0_GET: begin
				i_d = (s_q == CW'(1)) ? '0 : b_rd.bend + CW'(1);
				t_d = cnt_q - s_q;
				k_d = '0;
				acc_d = '0;
				ws_d = '0;
				state_d = sapava_pkg::S_TC_RD;
			end

			// save the blocks after the split one
			sapava_pkg::S_TC_RD: begin
				ba = s_q + CW'(1) + k_q;
				state_d = (k_q < t_q) ? sapava_pkg::S_TC_WR : sapava_pkg::S_SUM_RD;
			end
			sapava_pkg::S_TC_WR: begin
				t_we = 1'b1;
				t_wa = k_q;
				t_wd = b_rd;
				k_d = k_q + CW'(1);
				state_d = sapava_pkg::S_TC_RD;
			end

			// weighted sum over the left part of the split block
			sapava_pkg::S_SUM_RD: begin
				pa = i_q;
				state_d = sapava_pkg::S_SUM_MUL;
			end
			sapava_pkg::S_SUM_MUL: begin
				mul_a = w_rd;
				mul_b = {1'b0, f_rd};
				prod_d = prod_c;
				sh_d = 1'b0;
				ws_d = ws_q + BWW'(w_rd);
				state_d = sapava_pkg::S_SUM_ADD;
			end
			sapava_pkg::S_SUM_ADD: begin
				acc_d = acc_q + NW'(prod_q);
				if (i_q == CW'(j_q)) state_d = sapava_pkg::S_SUM_DIV;
				else begin
					i_d = i_q + CW'(1);
					state_d = sapava_pkg::S_SUM_RD;
				end
			end
			sapava_pkg::S_SUM_DIV: begin
				cur_d = '{bend: CW'(j_q), wt: ws_q, mean: '0};
				d_d = s_q;
				in_sg_d = 1'b0;
				if (ws_q == '0) state_d = sapava_pkg::S_PL_CHK;
				else begin
					div_start = 1'b1;
					state_d = sapava_pkg::S_SUM_WAIT;
				end
			end
			sapava_pkg::S_SUM_WAIT: begin
				if (div_done) begin
					cur_d.mean = div_q;
					state_d = sapava_pkg::S_PL_CHK;
				end
			end

			// pool adjacent violators, top block held in registers
			sapava_pkg::S_PL_CHK: begin
				ba = d_q - CW'(1);
				state_d = (d_q > CW'(1)) ? sapava_pkg::S_PL_CMP : sapava_pkg::S_PL_DONE;
			end
			sapava_pkg::S_PL_CMP: begin
				if (b_rd.mean <= cur_q.mean) begin
					prv_d = b_rd;
					acc_d = '0;
					step_d = '0;
					state_d = sapava_pkg::S_PL_MUL;
				end else state_d = sapava_pkg::S_PL_DONE;
			end
			sapava_pkg::S_PL_MUL: begin
				case (step_q)
					2'd0: begin mul_a = prv_q.wt[31:0]; mul_b = prv_q.mean; end
					2'd1: begin mul_a = 32'(prv_q.wt[BWW-1:32]); mul_b = prv_q.mean; end
					2'd2: begin mul_a = cur_q.wt[31:0]; mul_b = cur_q.mean; end
					default: begin mul_a = 32'(cur_q.wt[BWW-1:32]); mul_b = cur_q.mean; end
				endcase
				prod_d = prod_c;
				sh_d = step_q[0];
				state_d = sapava_pkg::S_PL_ADD;
			end
			sapava_pkg::S_PL_ADD: begin
				acc_d = acc_q + (sh_q ? NW'({prod_q, 32'd0}) : NW'(prod_q));
				if (step_q == 2'd3) begin
					ws_d = prv_q.wt + cur_q.wt;
					state_d = sapava_pkg::S_PL_DIVS;
				end else begin
					step_d = step_q + 2'd1;
					state_d = sapava_pkg::S_PL_MUL;
				end
			end
			sapava_pkg::S_PL_DIVS: begin
				if (ws_q == '0) begin
					cur_d.wt = '0;
					cur_d.mean = '0;
					d_d = d_q - CW'(1);
					state_d = sapava_pkg::S_PL_CHK;
				end else begin
					div_start = 1'b1;
					state_d = sapava_pkg::S_PL_WAIT;
				end
			end
			sapava_pkg::S_PL_WAIT: begin
				if (div_done) begin
					cur_d.wt = ws_q;
					cur_d.mean = div_q;
					d_d = d_q - CW'(1);
					state_d = sapava_pkg::S_PL_CHK;
				end
			end
			sapava_pkg::S_PL_DONE: begin
				b_we = 1'b1;
				b_wa = d_q;
				b_wd = cur_q;
				if (!in_sg_q) begin
					in_sg_d = 1'b1;
					i_d = CW'(j_q) + CW'(1);
				end else i_d = i_q + CW'(1);
				state_d = sapava_pkg::S_SG_CHK;
			end

			// right part of the split block re-enters as single positions
			sapava_pkg::S_SG_CHK: begin
				pa = i_q;
				k_d = '0;
				state_d = (i_q <= b0_q) ? sapava_pkg::S_SG_GET : sapava_pkg::S_TL_RD;
			end
			sapava_pkg::S_SG_GET: begin
				cur_d = '{bend: i_q, wt: BWW'(w_rd), mean: BMW'(f_rd)};
				d_d = d_q + CW'(1);
				state_d = sapava_pkg::S_PL_CHK;
			end

			// put the saved blocks back after the pooled ones
			sapava_pkg::S_TL_RD: begin
				ta = k_q;
				if (k_q < t_q && d_q < MAXP) state_d = sapava_pkg::S_TL_WR;
				else begin
					cnt_d = d_q;
					state_d = sapava_pkg::S_DONE;
				end
			end
			sapava_pkg::S_TL_WR: begin
				b_we = 1'b1;
				b_wa = d_q + CW'(1);
				b_wd = t_rd;
				d_d = d_q + CW'(1);
				k_d = k_q + CW'(1);
				state_d = sapava_pkg::S_TL_RD;
			end

			sapava_pkg::S_DONE: begin
				prev_d = y_q;
				first_d = 1'b1;
				state_d = sapava_pkg::S_IDLE;
			end
			default: state_d = sapava_pkg::S_IDLE;
		endcase

		// run clear from finish or a register write
		fclr = clr_run;
		if (clr_run) begin
			cnt_d = '0;
			cursor_d = '0;
			prev_d = '0;
			first_d = 1'b0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sapava_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			prev_q <= '0;
			first_q <= 1'b0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			prev_q <= prev_d;
			first_q <= first_d;
			cnt_q <= cnt_d;
			ovalid_q <= ovalid_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		func_q <= func_d; j_q <= j_d; amt_q <= amt_d; y_q <= y_d;
		c_q <= c_d; cols_q <= cols_d; p_q <= p_d; s_q <= s_d; b0_q <= b0_d;
		i_q <= i_d; k_q <= k_d; t_q <= t_d; d_q <= d_d; scan_b_q <= scan_b_d;
		ones_q <= ones_d; in_sg_q <= in_sg_d; sh_q <= sh_d; v_q <= v_d;
		frac_q <= frac_d; cur_q <= cur_d; prv_q <= prv_d; acc_q <= acc_d;
		ws_q <= ws_d; prod_q <= prod_d; step_q <= step_d;
		olast_q <= olast_d; opos_q <= opos_d; ofv_q <= ofv_d; occ_q <= occ_d;
	end

	assign out_valid = ovalid_q;
	assign out_position = opos_q;
	assign fitted_value = ofv_q;
	assign column_count = occ_q;
	assign last = olast_q;
	assign stat = '{m_eff: m_eff, div_busy: div_busy};
endmodule

FILE: hw/rtl/sequential_antitonic_pava_cdf.sv
// Top level: configuration registers on the APB-style port, sequencer core, checks.
// Depends on sapava_pkg and sapava_core.

// Sequential antitonic PAVA CDF fit. Loads (func 0 and 2) are taken in the idle state. An
// observation scans the grid points, walks the positions and blocks for a snapshot (which
// the output can stall), and for the fit runs one division for the fraction increment,
// sums each position into the split block, runs one division for its mean, pools the
// violators with a division per merge and copies the trailing blocks back. Finish emits
// one value per position in use once observations have been taken and grid columns remain.
// No clearing pass is needed after reset or finish: fractions carry valid bits and blocks
// are tracked by a count.
module sequential_antitonic_pava_cdf #(
	parameter int MAX_POSITIONS = sapava_pkg::MAX_POSITIONS_DEF,
	parameter int MAX_GRID = sapava_pkg::MAX_GRID_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [5:0] position,
	input  logic [31:0] amount,
	input  logic signed [31:0] y_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [5:0] out_position,
	output logic [31:0] fitted_value,
	output logic [6:0] column_count,
	output logic last
);
	localparam int CW = sapava_pkg::CW;

	logic [CW-1:0] m_q, g_q;
	logic wr;
	sapava_pkg::cfg_t cfg;
	sapava_pkg::stat_t stat;

	// register writes; either one restarts the run
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= sapava_pkg::REG_RESET;
			g_q <= sapava_pkg::REG_RESET;
		end else if (wr) begin
			if (paddr[2] == sapava_pkg::REG_POSITIONS) m_q <= pwdata[CW-1:0];
			else g_q <= pwdata[CW-1:0];
		end
	end

	assign prdata = (paddr[2] == sapava_pkg::REG_GRID) ? 32'(g_q) : 32'(m_q);
	assign cfg = '{m: m_q, g: g_q, clear: wr};

	sapava_core #(.MAX_POSITIONS(MAX_POSITIONS), .MAX_GRID(MAX_GRID)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .stat(stat),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .position(position),
		.amount(amount), .y_value(y_value),
		.out_valid(out_valid), .out_ready(out_ready), .out_position(out_position),
		.fitted_value(fitted_value), .column_count(column_count), .last(last)
	);

	// the last flag marks the final position in use
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_position == 6'(stat.m_eff - 7'd1))
		else $error("last flag on wrong position");

	// every snapshot covers at least one grid column
	a_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> column_count != 7'd0 && column_count <= 7'(MAX_GRID))
		else $error("bad column count");

	// fitted values never exceed one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fitted_value <= sapava_pkg::ONE_Q31)
		else $error("fitted value above one");

	// no request is taken while a division is running
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("ready during division");
endmodule
